@@ src/swet_pkg.sv @@
// Shared types and constants for the sliding window event threshold block.
package swet_pkg;

  localparam int STAMP_W     = 48;
  localparam int LIMIT_W     = STAMP_W + 1;
  localparam int COUNT_W     = 7;
  localparam int CLIMIT_W    = 6;
  localparam int WSEC_W      = 16;
  localparam int WMS_W       = 26;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int MS_PER_S    = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 1'b1;

  typedef logic [STAMP_W-1:0]        stamp_t;
  typedef logic signed [LIMIT_W-1:0] limit_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef struct packed {
    logic   wr;
    logic   in_ring;
    stamp_t stamp;
    limit_t limit;
  } cell_ctrl_t;

endpackage

@@ src/swet_if.sv @@
// Handshake interfaces for the event, result and configuration channels.
interface swet_event_if import swet_pkg::*; ();
  logic   valid;
  logic   ready;
  stamp_t event_time_ms;
  modport source (output valid, output event_time_ms, input ready);
  modport sink   (input valid, input event_time_ms, output ready);
endinterface

interface swet_result_if import swet_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t event_count;
  logic   limit_exceeded;
  modport source (output valid, output event_count, output limit_exceeded, input ready);
  modport sink   (input valid, input event_count, input limit_exceeded, output ready);
endinterface

interface swet_cfg_if import swet_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/sliding_window_event_threshold.sv @@
// Top level: sliding window event counter with threshold flag.
//
//   channel  dir  payload                            word accepted when
//   evt      in   event_time_ms[47:0]                evt.valid && evt.ready
//   res      out  event_count[6:0], limit_exceeded   res.valid && res.ready
//   cfg      in   index[0], data[15:0]               cfg.valid && cfg.ready
//
// An event occupies the block while it writes its slot and then while the window count
// ripples through the chain of slot cells, one cell per cycle.
// The result sits in an output register; the next event is taken while it waits.
// Reset (rst, synchronous) clears all slot valid bits, the write pointer and
// the registers to count_limit 0 and window_seconds 1.
// A stalled result holds the next event in the count state until the output
// register frees.
module sliding_window_event_threshold import swet_pkg::*; #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  swet_event_if.sink           evt,
  swet_result_if.source        res,
  swet_cfg_if.sink             cfg
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CMP_W  = (SLOT_W > CLIMIT_W) ? SLOT_W : CLIMIT_W;
  localparam int STEP_W = $clog2(MAX_SLOTS + 2);
  localparam logic [CMP_W-1:0] TOP_MAX = CMP_W'(MAX_SLOTS - 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_COUNT = 1'b1;

  logic                state;
  logic [STEP_W-1:0]   step;
  logic [CLIMIT_W-1:0] count_limit;
  logic [WMS_W-1:0]    window_ms;
  logic [SLOT_W-1:0]   write_slot;
  logic [SLOT_W-1:0]   top;
  logic [SLOT_W-1:0]   slot;
  logic [CMP_W-1:0]    lim_ext;
  stamp_t              stamp;
  limit_t              limit;
  logic                wr;
  logic                out_valid;
  count_t              out_count;
  logic                out_exceeded;
  logic                evt_take;
  logic                load;
  cell_ctrl_t          ctrl [MAX_SLOTS];
  count_t              cnt  [MAX_SLOTS+1];

  assign lim_ext  = CMP_W'(count_limit);
  assign top      = SLOT_W'((lim_ext > TOP_MAX) ? TOP_MAX : lim_ext);
  assign slot     = (write_slot > top) ? '0 : write_slot;
  assign evt.ready = (state == ST_IDLE);
  assign evt_take = evt.valid && evt.ready;
  assign load     = (state == ST_COUNT) && (step == STEP_W'(MAX_SLOTS + 1)) &&
                    (!out_valid || res.ready);
  assign cfg.ready = 1'b1;

  assign res.valid          = out_valid;
  assign res.event_count    = out_count;
  assign res.limit_exceeded = out_exceeded;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit <= '0;
      window_ms   <= WMS_W'(MS_PER_S);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_COUNT_LIMIT:    count_limit <= cfg.data[CLIMIT_W-1:0];
        REG_WINDOW_SECONDS: window_ms   <= WMS_W'(cfg.data[WSEC_W-1:0]) * WMS_W'(MS_PER_S);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      write_slot <= '0;
      wr         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      wr <= evt_take;
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (evt_take) begin
            state      <= ST_COUNT;
            step       <= '0;
            write_slot <= (slot >= top) ? '0 : slot + 1'b1;
          end
        end
        ST_COUNT: begin
          if (step != STEP_W'(MAX_SLOTS + 1)) begin
            step <= step + 1'b1;
          end else if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic [SLOT_W-1:0] wr_slot;

  always_ff @(posedge clk) begin
    if (evt_take) begin
      stamp   <= evt.event_time_ms;
      wr_slot <= slot;
      limit   <= $signed({1'b0, evt.event_time_ms}) -
                 $signed({{(LIMIT_W-WMS_W){1'b0}}, window_ms});
    end
    if (load) begin
      out_count    <= cnt[MAX_SLOTS];
      out_exceeded <= (cnt[MAX_SLOTS] > COUNT_W'(count_limit));
    end
  end

  assign cnt[0] = '0;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    assign ctrl[i].wr      = wr && (wr_slot == SLOT_W'(i));
    assign ctrl[i].in_ring = (SLOT_W'(i) <= top);
    assign ctrl[i].stamp   = stamp;
    assign ctrl[i].limit   = limit;

    swet_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl[i]),
      .cnt_in  (cnt[i]),
      .cnt_out (cnt[i+1])
    );
  end

endmodule

@@ src/swet_cell.sv @@
// One ring slot: stored stamp, valid bit and one stage of the count chain.
module swet_cell import swet_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  count_t     cnt_in,
  output count_t     cnt_out
);

  stamp_t stamp;
  logic   valid;
  logic   match;

  assign match = valid && ctrl.in_ring && ($signed({1'b0, stamp}) >= ctrl.limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.wr) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      stamp <= ctrl.stamp;
    end
    cnt_out <= cnt_in + count_t'(match);
  end

endmodule

@@ src/swet_checker.sv @@
// Port-level assertions for the sliding window event threshold block.
module swet_checker import swet_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   evt_valid,
  input logic   evt_ready,
  input logic   res_valid,
  input logic   res_ready,
  input count_t event_count,
  input logic   limit_exceeded
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(event_count) && $stable(limit_exceeded))
    else $error("result word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (event_count != 0) && (event_count <= 7'd64))
    else $error("event count outside one to sixty-four");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready |=> !evt_ready)
    else $error("event taken while previous event in progress");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!evt_ready))
    else $error("result appeared without an event in progress");

endmodule

bind sliding_window_event_threshold swet_checker u_swet_checker (
  .clk            (clk),
  .rst            (rst),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .event_count    (res.event_count),
  .limit_exceeded (res.limit_exceeded)
);
